@@ rtl/kruskal_edge_filter_union_find_defines.svh @@
// ----------------------------------------------------------------------------
// kruskal edge filter assertion macros
// checks on the sequencer datapath, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_EDGE_FILTER_UNION_FIND_DEFINES_SVH
`define KRUSKAL_EDGE_FILTER_UNION_FIND_DEFINES_SVH
`ifndef SYNTH
// property that must hold in the same cycle
`define KEFUF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("kefuf check failed");
// condition that must be followed by a result in the next cycle
`define KEFUF_ASSERT_NEXT(label, cond, nxt) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error("kefuf check failed");
`else
`define KEFUF_ASSERT(label, prop)
`define KEFUF_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

@@ rtl/kefuf_pkg.sv @@
// ----------------------------------------------------------------------------
// kefuf_pkg
// shared widths, microcode step names and control word layout
// ----------------------------------------------------------------------------
`default_nettype none

package kefuf_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VID_W        = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = 11;
    localparam int SIZE_W       = 11;
    localparam int WEIGHT_W     = 32;
    localparam int COUNT_W      = 10;
    localparam int WORD_W       = SIZE_W + VID_W;
    localparam int STEP_W       = 5;

    localparam int S_TDATA_W    = ((2 * VID_W + WEIGHT_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((WEIGHT_W + COUNT_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [STEP_W-1:0] {
        ST_RST_SWEEP  = 5'd0,
        ST_IDLE       = 5'd1,
        ST_DECIDE     = 5'd2,
        ST_CLEAR      = 5'd3,
        ST_SWEEP      = 5'd4,
        ST_CHECK      = 5'd5,
        ST_FIND_INIT  = 5'd6,
        ST_FIND_WALK  = 5'd7,
        ST_COMP_READ  = 5'd8,
        ST_COMP_TEST  = 5'd9,
        ST_COMP_WRITE = 5'd10,
        ST_FIND_DONE  = 5'd11,
        ST_SAME       = 5'd12,
        ST_READ_X     = 5'd13,
        ST_READ_Y     = 5'd14,
        ST_MERGE      = 5'd15,
        ST_LINK       = 5'd16,
        ST_WAIT       = 5'd17,
        ST_EMIT       = 5'd18
    } step_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_READ,
        MEM_WRITE
    } mem_op_t;

    typedef enum logic [2:0] {
        ADDR_SWEEP,
        ADDR_START,
        ADDR_DATA_PARENT,
        ADDR_CUR,
        ADDR_X,
        ADDR_ROOT,
        ADDR_BIG,
        ADDR_SMALL
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_INIT,
        WD_COMPRESS,
        WD_MERGE_BIG,
        WD_LINK_SMALL
    } wdata_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH_IN,
        OP_CLEAR,
        OP_SWEEP_STEP,
        OP_FIND_INIT,
        OP_ROOT_STEP,
        OP_CUR_STEP,
        OP_SAVE_ROOT,
        OP_LATCH_X,
        OP_MERGE,
        OP_ACCEPT,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_BEAT,
        COND_NOT_FIRST,
        COND_N_ZERO,
        COND_SWEEP_MORE,
        COND_RST_MORE,
        COND_OUT_RANGE,
        COND_PARENT_NE_ROOT,
        COND_PARENT_EQ_ROOT,
        COND_NOT_PASS_B,
        COND_SAME_SET,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        mem_op_t    mem_op;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        dp_op_t     op;
        cond_t      cond;
        step_t      target;
        logic       in_ready;
    } ctrl_t;

    typedef struct packed {
        logic beat;
        logic first;
        logic n_zero;
        logic sweep_more;
        logic rst_more;
        logic out_range;
        logic parent_eq_root;
        logic pass_b;
        logic same_set;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/kruskal_edge_filter_union_find.sv @@
// ----------------------------------------------------------------------------
// kruskal_edge_filter_union_find
// union-find edge filter for sorted edges, microcoded over a single-port forest
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                       tuser
// s_        in   vertex_a, vertex_b, edge_weight, pad     first_edge
// m_        out  tree_weight, tree_edges, pad             accepted
// cfg_wr_*  in   vertex_count                             -
//
// a joining edge is checked, walked, merged, linked and emitted before the next beat
// each extra level adds a walk step, each node compressed a read, test and write
// a first edge adds a clear step plus a sweep that rewrites the set of each vertex
// after reset a clearing pass over all 1024 entries runs before the first beat is taken
// the single-port forest memory sets the pace: one read or write per step
// a finished result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_edge_filter_union_find
    import kefuf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [VCNT_W-1:0]    cfg_wr_data,  // vertex_count
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,      // vertex_a, vertex_b, edge_weight
    input  wire logic                 s_tuser,      // first_edge
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,      // tree_weight, tree_edges
    output logic                      m_tuser       // accepted
);

    ctrl_t ctrl;
    stat_t stat;

    kefuf_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    kefuf_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .ctrl        (ctrl),
        .stat        (stat)
    );

endmodule

`default_nettype wire

@@ rtl/kefuf_ucode_rom.sv @@
// ----------------------------------------------------------------------------
// kefuf_ucode_rom
// microcode program: one control word per sequencer step
// ----------------------------------------------------------------------------
`default_nettype none

module kefuf_ucode_rom
    import kefuf_pkg::*;
(
    input  step_t pc,
    output ctrl_t ctrl
);

    always_comb begin
        ctrl.mem_op    = MEM_NONE;
        ctrl.addr_sel  = ADDR_SWEEP;
        ctrl.wdata_sel = WD_INIT;
        ctrl.op        = OP_NONE;
        ctrl.cond      = COND_NEVER;
        ctrl.target    = ST_IDLE;
        ctrl.in_ready  = 1'b0;
        case (pc)
            ST_RST_SWEEP: begin
                ctrl.mem_op = MEM_WRITE;
                ctrl.op     = OP_SWEEP_STEP;
                ctrl.cond   = COND_RST_MORE;
                ctrl.target = ST_RST_SWEEP;
            end
            ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                ctrl.op       = OP_LATCH_IN;
                ctrl.cond     = COND_NO_BEAT;
                ctrl.target   = ST_IDLE;
            end
            ST_DECIDE: begin
                ctrl.cond   = COND_NOT_FIRST;
                ctrl.target = ST_CHECK;
            end
            ST_CLEAR: begin
                ctrl.op     = OP_CLEAR;
                ctrl.cond   = COND_N_ZERO;
                ctrl.target = ST_CHECK;
            end
            ST_SWEEP: begin
                ctrl.mem_op = MEM_WRITE;
                ctrl.op     = OP_SWEEP_STEP;
                ctrl.cond   = COND_SWEEP_MORE;
                ctrl.target = ST_SWEEP;
            end
            ST_CHECK: begin
                ctrl.cond   = COND_OUT_RANGE;
                ctrl.target = ST_WAIT;
            end
            ST_FIND_INIT: begin
                ctrl.mem_op   = MEM_READ;
                ctrl.addr_sel = ADDR_START;
                ctrl.op       = OP_FIND_INIT;
            end
            ST_FIND_WALK: begin
                // climb one level per cycle until the entry points to itself
                ctrl.mem_op   = MEM_READ;
                ctrl.addr_sel = ADDR_DATA_PARENT;
                ctrl.op       = OP_ROOT_STEP;
                ctrl.cond     = COND_PARENT_NE_ROOT;
                ctrl.target   = ST_FIND_WALK;
            end
            ST_COMP_READ: begin
                ctrl.mem_op   = MEM_READ;
                ctrl.addr_sel = ADDR_CUR;
            end
            ST_COMP_TEST: begin
                ctrl.cond   = COND_PARENT_EQ_ROOT;
                ctrl.target = ST_FIND_DONE;
            end
            ST_COMP_WRITE: begin
                ctrl.mem_op    = MEM_WRITE;
                ctrl.addr_sel  = ADDR_CUR;
                ctrl.wdata_sel = WD_COMPRESS;
                ctrl.op        = OP_CUR_STEP;
                ctrl.cond      = COND_ALWAYS;
                ctrl.target    = ST_COMP_READ;
            end
            ST_FIND_DONE: begin
                ctrl.op     = OP_SAVE_ROOT;
                ctrl.cond   = COND_NOT_PASS_B;
                ctrl.target = ST_FIND_INIT;
            end
            ST_SAME: begin
                ctrl.cond   = COND_SAME_SET;
                ctrl.target = ST_WAIT;
            end
            ST_READ_X: begin
                ctrl.mem_op   = MEM_READ;
                ctrl.addr_sel = ADDR_X;
            end
            ST_READ_Y: begin
                ctrl.mem_op   = MEM_READ;
                ctrl.addr_sel = ADDR_ROOT;
                ctrl.op       = OP_LATCH_X;
            end
            ST_MERGE: begin
                ctrl.mem_op    = MEM_WRITE;
                ctrl.addr_sel  = ADDR_BIG;
                ctrl.wdata_sel = WD_MERGE_BIG;
                ctrl.op        = OP_MERGE;
            end
            ST_LINK: begin
                ctrl.mem_op    = MEM_WRITE;
                ctrl.addr_sel  = ADDR_SMALL;
                ctrl.wdata_sel = WD_LINK_SMALL;
                ctrl.op        = OP_ACCEPT;
            end
            ST_WAIT: begin
                ctrl.cond   = COND_OUT_BUSY;
                ctrl.target = ST_WAIT;
            end
            ST_EMIT: begin
                ctrl.op     = OP_EMIT;
                ctrl.cond   = COND_ALWAYS;
                ctrl.target = ST_IDLE;
            end
            default: begin
                ctrl.cond   = COND_ALWAYS;
                ctrl.target = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/kefuf_datapath.sv @@
// ----------------------------------------------------------------------------
// kefuf_datapath
// forest memory, walk registers, totals and the stream ports
// ----------------------------------------------------------------------------
`default_nettype none
`include "kruskal_edge_filter_union_find_defines.svh"

module kefuf_datapath
    import kefuf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [VCNT_W-1:0]    cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser,
    input  wire ctrl_t                ctrl,
    output stat_t                     stat
);

    localparam int M_PAD = M_TDATA_W - WEIGHT_W - COUNT_W;

    // each word holds {set size, parent}
    logic [WORD_W-1:0]   forest_mem [MAX_VERTICES];
    logic [WORD_W-1:0]   rd_data_reg;

    logic [VCNT_W-1:0]   vcount_reg;
    logic                first_reg;
    logic [VID_W-1:0]    va_reg;
    logic [VID_W-1:0]    vb_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [VID_W-1:0]    root_reg;
    logic [VID_W-1:0]    cur_reg;
    logic [VID_W-1:0]    x_reg;
    logic                pass_b_reg;
    logic [SIZE_W-1:0]   wx_size_reg;
    logic [VID_W-1:0]    small_reg;
    logic [VID_W-1:0]    big_reg;
    logic [SIZE_W-1:0]   small_size_reg;
    logic [VID_W-1:0]    idx_reg;
    logic                acc_reg;
    logic [WEIGHT_W-1:0] sum_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                m_valid_reg;
    logic                m_acc_reg;
    logic [WEIGHT_W-1:0] m_sum_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic [VCNT_W-1:0]   n_eff;
    logic [VID_W-1:0]    data_parent;
    logic [SIZE_W-1:0]   data_size;
    logic [VID_W-1:0]    start_v;
    logic                swap;
    logic [VID_W-1:0]    big_v;
    logic [SIZE_W:0]     size_sum;
    logic [SIZE_W-1:0]   size_sat;
    logic [VID_W-1:0]    mem_addr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                beat;

    assign n_eff = (vcount_reg > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount_reg;
    assign data_parent = rd_data_reg[VID_W-1:0];
    assign data_size   = rd_data_reg[WORD_W-1:VID_W];
    assign start_v     = pass_b_reg ? vb_reg : va_reg;

    // union by size: root of a is x, root of b sits in root_reg
    assign swap     = wx_size_reg > data_size;
    assign big_v    = swap ? x_reg : root_reg;
    assign size_sum = {1'b0, wx_size_reg} + {1'b0, data_size};
    assign size_sat = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];

    assign beat     = s_tvalid && s_tready;
    assign s_tready = ctrl.in_ready;

    always_comb begin
        case (ctrl.addr_sel)
            ADDR_SWEEP:       mem_addr = idx_reg;
            ADDR_START:       mem_addr = start_v;
            ADDR_DATA_PARENT: mem_addr = data_parent;
            ADDR_CUR:         mem_addr = cur_reg;
            ADDR_X:           mem_addr = x_reg;
            ADDR_ROOT:        mem_addr = root_reg;
            ADDR_BIG:         mem_addr = big_v;
            ADDR_SMALL:       mem_addr = small_reg;
            default:          mem_addr = idx_reg;
        endcase
    end

    always_comb begin
        case (ctrl.wdata_sel)
            WD_INIT:       mem_wdata = {SIZE_W'(1), idx_reg};
            WD_COMPRESS:   mem_wdata = {data_size, root_reg};
            WD_MERGE_BIG:  mem_wdata = {size_sat, big_v};
            WD_LINK_SMALL: mem_wdata = {small_size_reg, big_reg};
            default:       mem_wdata = {SIZE_W'(1), idx_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mem_op == MEM_WRITE) begin
            forest_mem[mem_addr] <= mem_wdata;
        end
        if (ctrl.mem_op == MEM_READ) begin
            rd_data_reg <= forest_mem[mem_addr];
        end
    end

    // control state and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= VCNT_W'(MAX_VERTICES);
            idx_reg     <= '0;
            pass_b_reg  <= 1'b0;
            acc_reg     <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                OP_LATCH_IN: begin
                    if (beat) begin
                        pass_b_reg <= 1'b0;
                        acc_reg    <= 1'b0;
                    end
                end
                OP_CLEAR: begin
                    idx_reg   <= '0;
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                OP_SWEEP_STEP: idx_reg <= idx_reg + VID_W'(1);
                OP_SAVE_ROOT:  pass_b_reg <= 1'b1;
                OP_ACCEPT: begin
                    acc_reg <= 1'b1;
                    sum_reg <= sum_reg + w_reg;
                    if (count_reg != COUNT_MAX) begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
                OP_EMIT:       m_valid_reg <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // walk and payload registers
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LATCH_IN: begin
                if (beat) begin
                    first_reg <= s_tuser;
                    va_reg    <= s_tdata[VID_W-1:0];
                    vb_reg    <= s_tdata[2*VID_W-1:VID_W];
                    w_reg     <= s_tdata[2*VID_W+WEIGHT_W-1:2*VID_W];
                end
            end
            OP_FIND_INIT: begin
                root_reg <= start_v;
                cur_reg  <= start_v;
            end
            OP_ROOT_STEP: root_reg <= data_parent;
            OP_CUR_STEP:  cur_reg <= data_parent;
            OP_SAVE_ROOT: begin
                if (!pass_b_reg) begin
                    x_reg <= root_reg;
                end
            end
            OP_LATCH_X:   wx_size_reg <= data_size;
            OP_MERGE: begin
                big_reg        <= big_v;
                small_reg      <= swap ? root_reg : x_reg;
                small_size_reg <= swap ? data_size : wx_size_reg;
            end
            OP_EMIT: begin
                m_acc_reg   <= acc_reg;
                m_sum_reg   <= sum_reg;
                m_count_reg <= count_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_acc_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, m_count_reg, m_sum_reg};

    always_comb begin
        stat.beat           = beat;
        stat.first          = first_reg;
        stat.n_zero         = (n_eff == '0);
        stat.sweep_more     = (({1'b0, idx_reg} + VCNT_W'(1)) != n_eff);
        stat.rst_more       = (idx_reg != VID_W'(MAX_VERTICES - 1));
        stat.out_range      = ({1'b0, va_reg} >= n_eff) || ({1'b0, vb_reg} >= n_eff);
        stat.parent_eq_root = (data_parent == root_reg);
        stat.pass_b         = pass_b_reg;
        stat.same_set       = (x_reg == root_reg);
        stat.out_busy       = m_valid_reg && !m_tready;
    end

    `KEFUF_ASSERT(a_emit_slot_free, (ctrl.op == OP_EMIT) |-> !(m_valid_reg && !m_tready))
    `KEFUF_ASSERT_NEXT(a_emit_shows, ctrl.op == OP_EMIT, m_valid_reg)
    `KEFUF_ASSERT(a_link_distinct, (ctrl.op == OP_ACCEPT) |-> (small_reg != big_reg))
    `KEFUF_ASSERT(a_count_moves, ($past(aresetn) && (count_reg != $past(count_reg))) |-> ($past(ctrl.op == OP_ACCEPT) || $past(ctrl.op == OP_CLEAR)))
    `KEFUF_ASSERT(a_accept_has_edges, (m_valid_reg && m_acc_reg) |-> (m_count_reg != '0))

endmodule

`default_nettype wire

@@ rtl/kefuf_sequencer.sv @@
// ----------------------------------------------------------------------------
// kefuf_sequencer
// step counter with conditional jumps over the microcode rom
// ----------------------------------------------------------------------------
`default_nettype none

module kefuf_sequencer
    import kefuf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  taken;

    kefuf_ucode_rom u_rom (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    always_comb begin
        case (ctrl.cond)
            COND_NEVER:          taken = 1'b0;
            COND_ALWAYS:         taken = 1'b1;
            COND_NO_BEAT:        taken = !stat.beat;
            COND_NOT_FIRST:      taken = !stat.first;
            COND_N_ZERO:         taken = stat.n_zero;
            COND_SWEEP_MORE:     taken = stat.sweep_more;
            COND_RST_MORE:       taken = stat.rst_more;
            COND_OUT_RANGE:      taken = stat.out_range;
            COND_PARENT_NE_ROOT: taken = !stat.parent_eq_root;
            COND_PARENT_EQ_ROOT: taken = stat.parent_eq_root;
            COND_NOT_PASS_B:     taken = !stat.pass_b;
            COND_SAME_SET:       taken = stat.same_set;
            COND_OUT_BUSY:       taken = stat.out_busy;
            default:             taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.target : step_t'(pc_reg + STEP_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_RST_SWEEP;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire
